// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the palette fade design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// cond must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// File: design/pfb_pkg.sv
// ----------------------------------------------------------------------------
// pfb_pkg
// Shared types and constants of the palette fade blend pipeline.
// ----------------------------------------------------------------------------
package pfb_pkg;

    localparam int FIELD_BITS     = 8;
    localparam int CFG_INDEX_BITS = 2;

    typedef logic [FIELD_BITS-1:0]     field_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t REG_FADE_STEPS  = 2'd0;
    localparam cfg_index_t REG_FIRST_ENTRY = 2'd1;
    localparam cfg_index_t REG_LAST_ENTRY  = 2'd2;

    typedef struct packed {
        field_t fade_steps;
        field_t first_entry;
        field_t last_entry;
    } pfb_cfg_t;

    // per-item data that rides alongside the divider
    typedef struct packed {
        field_t orig;
        field_t divisor;
        logic   neg;
        logic   in_range;
    } pfb_side_t;

endpackage

// File: design/pfb_front.sv
// ----------------------------------------------------------------------------
// pfb_front
// Step clamp, range check, delta magnitude and product, one register stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfb_front import pfb_pkg::*; #(
    parameter int COMPONENT_BITS = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  pfb_cfg_t                             cfg,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  field_t                               entry_index,
    input  field_t                               original_value,
    input  field_t                               target_value,
    input  field_t                               step_index,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [COMPONENT_BITS+FIELD_BITS-1:0] out_prod,
    output pfb_side_t                            out_side
);

    localparam int CB = COMPONENT_BITS;
    localparam int PW = COMPONENT_BITS + FIELD_BITS;

    field_t        steps;
    field_t        step;
    logic [CB-1:0] orig;
    logic [CB-1:0] target;
    logic [CB-1:0] mag;
    logic [PW-1:0] prod_next;
    pfb_side_t     side_next;

    logic          valid_reg;
    logic [PW-1:0] prod_reg;
    pfb_side_t     side_reg;

    always_comb begin
        steps  = (cfg.fade_steps == '0) ? field_t'(1) : cfg.fade_steps;
        step   = (step_index > steps) ? steps : step_index;
        orig   = original_value[CB-1:0];
        target = target_value[CB-1:0];
        mag    = (target < orig) ? (orig - target) : (target - orig);
        prod_next = PW'(mag) * PW'(step);
        side_next.orig     = field_t'(orig);
        side_next.divisor  = steps;
        side_next.neg      = (target < orig);
        side_next.in_range = (entry_index >= cfg.first_entry) &&
                             (entry_index <= cfg.last_entry);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            prod_reg <= prod_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_prod  = prod_reg;
    assign out_side  = side_reg;

    // quotient must fit in CB bits: high part of the dividend below divisor
    `ASSERT_NEVER(a_zero_divisor, aclk, aresetn, valid_reg && side_reg.divisor == '0)
    `ASSERT_CLK(a_quot_fits, aclk, aresetn, valid_reg |-> prod_reg[PW-1:CB] < side_reg.divisor)

endmodule

// File: design/pfb_div_stage.sv
// ----------------------------------------------------------------------------
// pfb_div_stage
// One registered slice of the restoring divider: ITERS quotient bits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfb_div_stage import pfb_pkg::*; #(
    parameter int COMPONENT_BITS = 8,
    parameter int ITERS          = 2
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  field_t                    in_rem,
    input  logic [COMPONENT_BITS-1:0] in_shreg,
    input  pfb_side_t                 in_side,
    output logic                      out_valid,
    input  logic                      out_ready,
    output field_t                    out_rem,
    output logic [COMPONENT_BITS-1:0] out_shreg,
    output pfb_side_t                 out_side
);

    localparam int CB = COMPONENT_BITS;

    field_t              rem_next;
    logic [CB-1:0]       shreg_next;
    logic [FIELD_BITS:0] trial;

    logic                valid_reg;
    field_t              rem_reg;
    logic [CB-1:0]       shreg_reg;
    pfb_side_t           side_reg;

    // shreg holds unused dividend bits on top, quotient bits shift in below
    always_comb begin
        rem_next   = in_rem;
        shreg_next = in_shreg;
        trial      = '0;
        for (int i = 0; i < ITERS; i++) begin
            trial = {rem_next, shreg_next[CB-1]};
            if (trial >= {1'b0, in_side.divisor}) begin
                rem_next   = field_t'(trial - {1'b0, in_side.divisor});
                shreg_next = {shreg_next[CB-2:0], 1'b1};
            end else begin
                rem_next   = trial[FIELD_BITS-1:0];
                shreg_next = {shreg_next[CB-2:0], 1'b0};
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            rem_reg   <= rem_next;
            shreg_reg <= shreg_next;
            side_reg  <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_shreg = shreg_reg;
    assign out_side  = side_reg;

    `ASSERT_CLK(a_rem_below_div, aclk, aresetn, valid_reg |-> rem_reg < side_reg.divisor)

endmodule

// File: design/palette_fade_blend.sv
// ----------------------------------------------------------------------------
// palette_fade_blend
// One color component of a linear palette fade frame:
// orig + (target - orig) * step / steps, quotient truncated toward zero.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  s_        in         s_valid / s_ready     entry_index, original_value,
//                                             target_value, step_index
//  m_        out        m_valid / m_ready     blended_value
//  cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
//  One transaction per cycle sustained while m_ready holds high. Stages in
//  order: product stage, a restoring divider of up to two quotient bits per
//  stage, output register.
//  aresetn is synchronous; it clears all valid bits and loads register defaults.
//  Each stage holds while full and blocked downstream; input stays ready
//  while a result waits until all six registers (at 8 bits) hold items.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module palette_fade_blend import pfb_pkg::*; #(
    parameter int COMPONENT_BITS = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  field_t     s_entry_index,
    input  field_t     s_original_value,
    input  field_t     s_target_value,
    input  field_t     s_step_index,
    output logic       m_valid,
    input  logic       m_ready,
    output field_t     m_blended_value,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  cfg_index_t cfg_index,
    input  field_t     cfg_data
);

    localparam int          CB   = COMPONENT_BITS;
    localparam int          PW   = COMPONENT_BITS + FIELD_BITS;
    localparam int          NST  = (COMPONENT_BITS + 1) / 2;
    localparam logic [CB:0] MASK = {1'b0, {CB{1'b1}}};

    pfb_cfg_t      cfg_reg;

    logic [PW-1:0] front_prod;
    logic          st_valid [NST+1];
    logic          st_ready [NST+1];
    field_t        st_rem   [NST+1];
    logic [CB-1:0] st_shreg [NST+1];
    pfb_side_t     st_side  [NST+1];

    logic [CB-1:0] quot;
    logic [CB-1:0] orig_cb;
    logic [CB:0]   sum;
    logic [CB-1:0] blend_next;
    logic          out_load;
    logic          bypass_load;
    field_t        out_orig;

    logic          m_valid_reg;
    field_t        m_blended_value_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fade_steps  <= field_t'(1);
            cfg_reg.first_entry <= '0;
            cfg_reg.last_entry  <= '1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_FADE_STEPS:  cfg_reg.fade_steps  <= cfg_data;
                REG_FIRST_ENTRY: cfg_reg.first_entry <= cfg_data;
                REG_LAST_ENTRY:  cfg_reg.last_entry  <= cfg_data;
                default: ;
            endcase
        end
    end

    pfb_front #(
        .COMPONENT_BITS(COMPONENT_BITS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .in_valid       (s_valid),
        .in_ready       (s_ready),
        .entry_index    (s_entry_index),
        .original_value (s_original_value),
        .target_value   (s_target_value),
        .step_index     (s_step_index),
        .out_valid      (st_valid[0]),
        .out_ready      (st_ready[0]),
        .out_prod       (front_prod),
        .out_side       (st_side[0])
    );

    assign st_rem[0]   = front_prod[PW-1:CB];
    assign st_shreg[0] = front_prod[CB-1:0];

    for (genvar s = 0; s < NST; s++) begin : g_div
        pfb_div_stage #(
            .COMPONENT_BITS (COMPONENT_BITS),
            .ITERS          (((2 * s + 2) <= COMPONENT_BITS) ? 2 : 1)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (st_valid[s]),
            .in_ready  (st_ready[s]),
            .in_rem    (st_rem[s]),
            .in_shreg  (st_shreg[s]),
            .in_side   (st_side[s]),
            .out_valid (st_valid[s+1]),
            .out_ready (st_ready[s+1]),
            .out_rem   (st_rem[s+1]),
            .out_shreg (st_shreg[s+1]),
            .out_side  (st_side[s+1])
        );
    end

    // final add, clamp, pass-through
    always_comb begin
        quot    = st_shreg[NST];
        orig_cb = st_side[NST].orig[CB-1:0];
        if (st_side[NST].neg) begin
            sum = (orig_cb >= quot) ? ({1'b0, orig_cb} - {1'b0, quot}) : '0;
        end else begin
            sum = {1'b0, orig_cb} + {1'b0, quot};
            if (sum > MASK) begin
                sum = MASK;
            end
        end
        blend_next = st_side[NST].in_range ? sum[CB-1:0] : orig_cb;
    end

    assign st_ready[NST] = !m_valid_reg || m_ready;
    assign out_load      = st_valid[NST] && st_ready[NST];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (st_ready[NST]) begin
            m_valid_reg <= st_valid[NST];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_blended_value_reg <= field_t'(blend_next);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_blended_value = m_blended_value_reg;

    assign bypass_load = out_load && !st_side[NST].in_range;
    assign out_orig    = st_side[NST].orig;

    `ASSERT_CLK(a_bypass_orig, aclk, aresetn, bypass_load |=> m_blended_value == $past(out_orig))
    `ASSERT_NEVER(a_neg_underflow, aclk, aresetn, st_valid[NST] && st_side[NST].neg && quot > orig_cb)

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palette_fade_blend testbench
// Drives directed and random color components through the fade blender under
// several register settings, with random idle cycles on both channels. Each
// accepted input is predicted in the scoreboard and every output transaction
// is compared in order against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import pfb_pkg::*;

    localparam int COMPONENT_BITS = 8;
    localparam int LATENCY        = 2 + (COMPONENT_BITS + 1) / 2;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 133;

    localparam cfg_index_t REG_UNUSED = cfg_index_t'(3);

    class fade_scoreboard;
        field_t      blend_q[$];
        field_t      steps_reg;
        field_t      first_reg;
        field_t      last_reg;
        int unsigned mismatches;

        function new();
            steps_reg  = 8'd1;
            first_reg  = 8'd0;
            last_reg   = 8'd255;
            mismatches = 0;
        endfunction

        function void write_reg(cfg_index_t idx, field_t data);
            case (idx)
                REG_FADE_STEPS:  steps_reg = data;
                REG_FIRST_ENTRY: first_reg = data;
                REG_LAST_ENTRY:  last_reg  = data;
                default: ;
            endcase
        endfunction

        function void note_input(field_t entry, field_t orig, field_t target, field_t step);
            int mask;
            int o;
            int t;
            int steps;
            int st;
            int res;
            mask  = (1 << COMPONENT_BITS) - 1;
            o     = int'(orig) & mask;
            t     = int'(target) & mask;
            steps = (steps_reg == 0) ? 1 : int'(steps_reg);
            st    = (int'(step) > steps) ? steps : int'(step);
            if (entry >= first_reg && entry <= last_reg) begin
                res = o + ((t - o) * st) / steps;
                if (res < 0) res = 0;
                if (res > mask) res = mask;
            end else begin
                res = o;
            end
            blend_q.push_back(field_t'(res));
        endfunction

        function void check_result(field_t actual);
            field_t want;
            if (blend_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output transaction: blended_value=%0d", actual);
                return;
            end
            want = blend_q.pop_front();
            if (actual !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("blended_value mismatch: expected %0d, actual %0d", want, actual);
            end
        endfunction

        function int pending();
            return blend_q.size();
        endfunction
    endclass

    logic       aclk             = 1'b0;
    logic       aresetn          = 1'b0;
    logic       s_valid          = 1'b0;
    logic       s_ready;
    field_t     s_entry_index    = '0;
    field_t     s_original_value = '0;
    field_t     s_target_value   = '0;
    field_t     s_step_index     = '0;
    logic       m_valid;
    logic       m_ready          = 1'b0;
    field_t     m_blended_value;
    logic       cfg_valid        = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index        = '0;
    field_t     cfg_data         = '0;

    fade_scoreboard sb;
    bit s_rush;
    bit m_rush;

    always #1 aclk = ~aclk;

    palette_fade_blend #(
        .COMPONENT_BITS(COMPONENT_BITS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_entry_index   (s_entry_index),
        .s_original_value(s_original_value),
        .s_target_value  (s_target_value),
        .s_step_index    (s_step_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_blended_value (m_blended_value),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    task automatic send_item(field_t entry, field_t orig, field_t target, field_t step);
        int gap;
        if ($urandom_range(0, 49) == 0) s_rush = !s_rush;
        gap = s_rush ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_entry_index    <= entry;
        s_original_value <= orig;
        s_target_value   <= target;
        s_step_index     <= step;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(entry, orig, target, step);
    endtask

    task automatic drain_results();
        int gap;
        forever begin
            if ($urandom_range(0, 49) == 0) m_rush = !m_rush;
            gap = m_rush ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_result(m_blended_value);
        end
    endtask

    task automatic write_reg(cfg_index_t idx, field_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge aclk);
    endtask

    // drop valid, wait for the pipeline to empty
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    task automatic random_config();
        field_t steps;
        field_t lo;
        field_t hi;
        field_t tmp;
        case ($urandom_range(0, 5))
            0:       steps = 8'd1;
            1:       steps = 8'd255;
            2:       steps = 8'd0;
            3:       steps = field_t'($urandom_range(1, 20));
            default: steps = field_t'($urandom_range(1, 255));
        endcase
        lo = field_t'($urandom_range(0, 255));
        hi = field_t'($urandom_range(0, 255));
        case ($urandom_range(0, 4))
            0: begin
                lo = 8'd0;
                hi = 8'd255;
            end
            1: hi = lo;
            2: ;
            default: begin
                if (lo > hi) begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
            end
        endcase
        case ($urandom_range(0, 2))
            0: begin
                write_reg(REG_FADE_STEPS, steps);
                write_reg(REG_FIRST_ENTRY, lo);
                write_reg(REG_LAST_ENTRY, hi);
            end
            1: begin
                write_reg(REG_LAST_ENTRY, hi);
                write_reg(REG_FADE_STEPS, steps);
                write_reg(REG_FIRST_ENTRY, lo);
            end
            default: begin
                write_reg(REG_FIRST_ENTRY, lo);
                write_reg(REG_LAST_ENTRY, hi);
                write_reg(REG_FADE_STEPS, steps);
            end
        endcase
    endtask

    task automatic random_phase(int count);
        field_t entry;
        field_t orig;
        field_t target;
        field_t step;
        int     steps;
        for (int i = 0; i < count; i++) begin
            steps = (sb.steps_reg == 0) ? 1 : int'(sb.steps_reg);
            case ($urandom_range(0, 7))
                0:       entry = sb.first_reg;
                1:       entry = sb.last_reg;
                2:       entry = sb.first_reg - 8'd1;
                3:       entry = sb.last_reg + 8'd1;
                default: entry = field_t'($urandom_range(0, 255));
            endcase
            orig   = field_t'($urandom_range(0, 255));
            target = field_t'($urandom_range(0, 255));
            if ($urandom_range(0, 7) == 0) orig   = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            if ($urandom_range(0, 7) == 0) target = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            if ($urandom_range(0, 1) == 0)
                step = field_t'($urandom_range(0, 255));
            else
                step = field_t'($urandom_range(0, (steps + 1 > 255) ? 255 : steps + 1));
            send_item(entry, orig, target, step);
        end
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        fork
            drain_results();
        join_none

        // register defaults: one step, full range
        send_item(8'd0,   8'd0,   8'd255, 8'd0);
        send_item(8'd255, 8'd255, 8'd0,   8'd1);
        send_item(8'd128, 8'd17,  8'd200, 8'd255);
        settle();

        write_reg(REG_FADE_STEPS, 8'd16);
        write_reg(REG_FIRST_ENTRY, 8'd10);
        write_reg(REG_LAST_ENTRY, 8'd200);
        send_item(8'd10,  8'd0,   8'd255, 8'd8);
        send_item(8'd200, 8'd255, 8'd0,   8'd3);
        send_item(8'd9,   8'd77,  8'd3,   8'd5);
        send_item(8'd201, 8'd77,  8'd3,   8'd5);
        send_item(8'd100, 8'd200, 8'd3,   8'd15);
        send_item(8'd100, 8'd200, 8'd3,   8'd16);
        send_item(8'd100, 8'd200, 8'd3,   8'd255);
        send_item(8'd100, 8'd0,   8'd255, 8'd0);
        send_item(8'd150, 8'd255, 8'd255, 8'd7);
        send_item(8'd150, 8'd1,   8'd0,   8'd1);
        settle();

        // zero step count, empty range, write to the unused index
        write_reg(REG_FADE_STEPS, 8'd0);
        write_reg(REG_FIRST_ENTRY, 8'd50);
        write_reg(REG_LAST_ENTRY, 8'd40);
        write_reg(REG_UNUSED, 8'hff);
        send_item(8'd45,  8'd10,  8'd250, 8'd0);
        send_item(8'd50,  8'd10,  8'd250, 8'd1);
        send_item(8'd0,   8'd200, 8'd100, 8'd1);
        send_item(8'd255, 8'd33,  8'd44,  8'd9);
        settle();

        write_reg(REG_FADE_STEPS, 8'd255);
        write_reg(REG_FIRST_ENTRY, 8'd128);
        write_reg(REG_LAST_ENTRY, 8'd128);
        send_item(8'd128, 8'd0,   8'd255, 8'd254);
        send_item(8'd128, 8'd255, 8'd0,   8'd128);
        send_item(8'd127, 8'd5,   8'd6,   8'd1);
        send_item(8'd129, 8'd5,   8'd6,   8'd1);
        send_item(8'd128, 8'd0,   8'd255, 8'd255);
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            random_config();
            random_phase(PHASE_ITEMS);
            settle();
        end

        repeat (4 * LATENCY) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("palette_fade_blend regression: pass");
        end else begin
            $display("palette_fade_blend regression: fail");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("palette_fade_blend regression: fail");
        $finish;
    end

endmodule
